### src/detector_pixel_to_reciprocal_coords_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pixel to reciprocal coordinate block
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef DETECTOR_PIXEL_TO_RECIPROCAL_COORDS_TOP_DEFINES_SVH
`define DETECTOR_PIXEL_TO_RECIPROCAL_COORDS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/dpr_pkg.sv
// ---------------------------------------------------------------------------
// dpr_pkg
// Types and constants shared by the pixel to reciprocal coordinate block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package dpr_pkg;

	localparam int OUT_W     = 40;
	localparam int STEP_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LO_W      = 32;
	localparam int HI_W      = OUT_W - LO_W;
	localparam int S_W       = 81;
	localparam int SQ_BITS   = 41;
	localparam int SQ_T_W    = 83;
	localparam int NUM_W     = 72;
	localparam int Q_BITS    = 32;
	localparam int DV_W      = 74;
	localparam int LATENCY   = 4 + SQ_BITS + Q_BITS + 1;

	localparam logic [1:0] MODE_EWALD = 2'd0;
	localparam logic [1:0] MODE_PLANE = 2'd1;
	localparam logic [1:0] MODE_GRID  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Z   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd7;

	typedef logic signed [OUT_W-1:0] coord_t;

	typedef struct packed {
		logic   neg_x;
		logic   neg_y;
		coord_t pln_x;
		coord_t pln_y;
		coord_t pln_z;
	} side_t;

	typedef struct packed {
		logic [S_W-1:0]     rem;
		logic [SQ_BITS-1:0] res;
		logic [NUM_W-1:0]   num_x;
		logic [NUM_W-1:0]   num_y;
		logic [NUM_W-1:0]   num_z;
	} sq_t;

	typedef struct packed {
		logic [NUM_W-1:0]   rem_x;
		logic [NUM_W-1:0]   rem_y;
		logic [NUM_W-1:0]   rem_z;
		logic [Q_BITS-1:0]  q_x;
		logic [Q_BITS-1:0]  q_y;
		logic [Q_BITS-1:0]  q_z;
		logic [SQ_BITS-1:0] d;
	} dv_t;

endpackage

### src/dpr_sqrt_cell.sv
// ---------------------------------------------------------------------------
// dpr_sqrt_cell
// One bit of a restoring square root, registered, with the item's side data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dpr_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  dpr_pkg::side_t side_i,
	input  dpr_pkg::sq_t   sq_i,
	output logic          vld_o,
	output dpr_pkg::side_t side_o,
	output dpr_pkg::sq_t   sq_o
);
	import dpr_pkg::*;

	logic [SQ_T_W-1:0] rem_ext;
	logic [SQ_T_W-1:0] trial;
	sq_t               sq_nxt;
	logic              vld_q;
	side_t             side_q;
	sq_t               sq_q;

	always_comb begin
		rem_ext = SQ_T_W'(sq_i.rem);
		trial   = (SQ_T_W'(sq_i.res) << (BIT + 1)) + (SQ_T_W'(1) << (2 * BIT));
		sq_nxt  = sq_i;
		if (trial <= rem_ext) begin
			sq_nxt.rem = S_W'(rem_ext - trial);
			sq_nxt.res = sq_i.res | (SQ_BITS'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		sq_q   <= sq_nxt;
	end

	assign vld_o  = vld_q;
	assign side_o = side_q;
	assign sq_o   = sq_q;
endmodule

### src/dpr_div_cell.sv
// ---------------------------------------------------------------------------
// dpr_div_cell
// One quotient bit of three restoring divisions by the sphere distance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dpr_div_cell #(
	parameter int BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_i,
	input  dpr_pkg::side_t side_i,
	input  dpr_pkg::dv_t   dv_i,
	output logic          vld_o,
	output dpr_pkg::side_t side_o,
	output dpr_pkg::dv_t   dv_o
);
	import dpr_pkg::*;

	logic [DV_W-1:0] dsh;
	logic [DV_W-1:0] rx_ext;
	logic [DV_W-1:0] ry_ext;
	logic [DV_W-1:0] rz_ext;
	dv_t             dv_nxt;
	logic            vld_q;
	side_t           side_q;
	dv_t             dv_q;

	always_comb begin
		dsh    = DV_W'(dv_i.d) << BIT;
		rx_ext = DV_W'(dv_i.rem_x);
		ry_ext = DV_W'(dv_i.rem_y);
		rz_ext = DV_W'(dv_i.rem_z);
		dv_nxt = dv_i;
		if (dsh <= rx_ext) begin
			dv_nxt.rem_x = NUM_W'(rx_ext - dsh);
			dv_nxt.q_x   = dv_i.q_x | (Q_BITS'(1) << BIT);
		end
		if (dsh <= ry_ext) begin
			dv_nxt.rem_y = NUM_W'(ry_ext - dsh);
			dv_nxt.q_y   = dv_i.q_y | (Q_BITS'(1) << BIT);
		end
		if (dsh <= rz_ext) begin
			dv_nxt.rem_z = NUM_W'(rz_ext - dsh);
			dv_nxt.q_z   = dv_i.q_z | (Q_BITS'(1) << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		side_q <= side_i;
		dv_q   <= dv_nxt;
	end

	assign vld_o  = vld_q;
	assign side_o = side_q;
	assign dv_o   = dv_q;
endmodule

### src/detector_pixel_to_reciprocal_coords_top.sv
// ---------------------------------------------------------------------------
// detector_pixel_to_reciprocal_coords_top
// Maps a detector pixel to reciprocal-space coordinates: grid, plane or
// Ewald sphere projection through a chain of square root and divide cells.
//
// Channel   Direction  Handshake          Payload
// input     in         start, busy        pix_x, pix_y, pix_z
// result    out        done (one cycle)   recip_x, recip_y, recip_z
// config    in         cfg_we             cfg_index, cfg_data
//
// One item is taken every cycle; each result passes through four front
// stages, 41 square root cells, 32 divide cells and the output register.
// Reset clears all valid flags and loads mode 2.
// Busy is always low and the receiver cannot stall the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module detector_pixel_to_reciprocal_coords_top #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [COORD_BITS-1:0]              pix_x,
	input  logic [COORD_BITS-1:0]              pix_y,
	input  logic [COORD_BITS-1:0]              pix_z,
	output logic                               done,
	output logic signed [dpr_pkg::OUT_W-1:0]   recip_x,
	output logic signed [dpr_pkg::OUT_W-1:0]   recip_y,
	output logic signed [dpr_pkg::OUT_W-1:0]   recip_z,
	input  logic                               cfg_we,
	input  logic [dpr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dpr_pkg::CFG_W-1:0]          cfg_data
);
	import dpr_pkg::*;

	localparam int PM_W  = COORD_BITS + STEP_W;
	localparam int EXT_W = (PM_W > OUT_W) ? PM_W : OUT_W + 1;
	localparam logic [EXT_W-1:0] LIM_POS = EXT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [EXT_W-1:0] LIM_NEG = EXT_W'(64'd1 << (OUT_W - 1));

	logic [1:0]            mode_q;
	logic [COORD_BITS-1:0] center_x_q, center_y_q, center_z_q;
	logic [STEP_W-1:0]     step_x_q, step_y_q, step_z_q, radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_GRID;
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			step_x_q   <= '0;
			step_y_q   <= '0;
			step_z_q   <= '0;
			radius_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[1:0];
				REG_CENTER_X: center_x_q <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Y: center_y_q <= cfg_data[COORD_BITS-1:0];
				REG_CENTER_Z: center_z_q <= cfg_data[COORD_BITS-1:0];
				REG_STEP_X:   step_x_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:   step_y_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_Z:   step_z_q   <= cfg_data[STEP_W-1:0];
				REG_RADIUS:   radius_q   <= cfg_data[STEP_W-1:0];
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: offsets from the centre and their products with the steps.
	logic signed [COORD_BITS:0] dx, dy, dz;
	logic [COORD_BITS-1:0]      mx, my, mz;
	logic                       vld_s1;
	logic [PM_W-1:0]            px_s1, py_s1, pz_s1;
	logic                       dnx_s1, dny_s1, dnz_s1;

	always_comb begin
		dx = $signed({1'b0, pix_x}) - $signed({1'b0, center_x_q});
		dy = $signed({1'b0, center_y_q}) - $signed({1'b0, pix_y});
		dz = $signed({1'b0, center_z_q}) - $signed({1'b0, pix_z});
		mx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		my = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		mz = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
	end

	// Stage 2: saturation and signed plane values.
	logic [EXT_W-1:0]   ex, ey, ez;
	logic               ngx, ngy, ngz;
	logic [OUT_W-1:0]   sx, sy, sz;
	logic               vld_s2;
	logic [OUT_W-1:0]   rx_s2, ry_s2;
	side_t              side_s2;

	always_comb begin
		ex  = EXT_W'(px_s1);
		ey  = EXT_W'(py_s1);
		ez  = EXT_W'(pz_s1);
		ngx = dnx_s1 && (px_s1 != '0);
		ngy = dny_s1 && (py_s1 != '0);
		ngz = dnz_s1 && (pz_s1 != '0);
		if (ngx) sx = OUT_W'((ex > LIM_NEG) ? LIM_NEG : ex);
		else     sx = OUT_W'((ex > LIM_POS) ? LIM_POS : ex);
		if (ngy) sy = OUT_W'((ey > LIM_NEG) ? LIM_NEG : ey);
		else     sy = OUT_W'((ey > LIM_POS) ? LIM_POS : ey);
		if (ngz) sz = OUT_W'((ez > LIM_NEG) ? LIM_NEG : ez);
		else     sz = OUT_W'((ez > LIM_POS) ? LIM_POS : ez);
	end

	// Stage 3: partial products for the squares and numerators.
	logic                   vld_s3;
	side_t                  side_s3;
	logic [2*LO_W-1:0]      sqlo_x_s3, sqlo_y_s3, rr_s3, mlo_x_s3, mlo_y_s3;
	logic [HI_W+LO_W-1:0]   crs_x_s3, crs_y_s3, mhi_x_s3, mhi_y_s3;
	logic [2*HI_W-1:0]      sqhi_x_s3, sqhi_y_s3;

	// Stage 4: sums.
	logic                   vld_s4;
	side_t                  side_s4;
	sq_t                    sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		px_s1  <= PM_W'(mx) * PM_W'(step_x_q);
		py_s1  <= PM_W'(my) * PM_W'(step_y_q);
		pz_s1  <= PM_W'(mz) * PM_W'(step_z_q);
		dnx_s1 <= dx[COORD_BITS];
		dny_s1 <= dy[COORD_BITS];
		dnz_s1 <= dz[COORD_BITS];

		rx_s2         <= sx;
		ry_s2         <= sy;
		side_s2.neg_x <= ngx;
		side_s2.neg_y <= ngy;
		side_s2.pln_x <= ngx ? -$signed(sx) : $signed(sx);
		side_s2.pln_y <= ngy ? -$signed(sy) : $signed(sy);
		side_s2.pln_z <= ngz ? -$signed(sz) : $signed(sz);

		side_s3   <= side_s2;
		sqlo_x_s3 <= rx_s2[LO_W-1:0] * rx_s2[LO_W-1:0];
		sqlo_y_s3 <= ry_s2[LO_W-1:0] * ry_s2[LO_W-1:0];
		crs_x_s3  <= rx_s2[OUT_W-1:LO_W] * rx_s2[LO_W-1:0];
		crs_y_s3  <= ry_s2[OUT_W-1:LO_W] * ry_s2[LO_W-1:0];
		sqhi_x_s3 <= rx_s2[OUT_W-1:LO_W] * rx_s2[OUT_W-1:LO_W];
		sqhi_y_s3 <= ry_s2[OUT_W-1:LO_W] * ry_s2[OUT_W-1:LO_W];
		rr_s3     <= radius_q * radius_q;
		mlo_x_s3  <= rx_s2[LO_W-1:0] * radius_q;
		mlo_y_s3  <= ry_s2[LO_W-1:0] * radius_q;
		mhi_x_s3  <= rx_s2[OUT_W-1:LO_W] * radius_q;
		mhi_y_s3  <= ry_s2[OUT_W-1:LO_W] * radius_q;

		side_s4   <= side_s3;
		sq_s4.rem <= (S_W'(sqhi_x_s3) << (2 * LO_W)) + (S_W'(crs_x_s3) << (LO_W + 1))
			+ S_W'(sqlo_x_s3) + (S_W'(sqhi_y_s3) << (2 * LO_W))
			+ (S_W'(crs_y_s3) << (LO_W + 1)) + S_W'(sqlo_y_s3) + S_W'(rr_s3);
		sq_s4.res   <= '0;
		sq_s4.num_x <= (NUM_W'(mhi_x_s3) << LO_W) + NUM_W'(mlo_x_s3);
		sq_s4.num_y <= (NUM_W'(mhi_y_s3) << LO_W) + NUM_W'(mlo_y_s3);
		sq_s4.num_z <= NUM_W'(rr_s3);
	end

	logic  sq_vld  [0:SQ_BITS];
	side_t sq_side [0:SQ_BITS];
	sq_t   sq_dat  [0:SQ_BITS];

	assign sq_vld[0]  = vld_s4;
	assign sq_side[0] = side_s4;
	assign sq_dat[0]  = sq_s4;

	for (genvar i = 0; i < SQ_BITS; i++) begin : g_sqrt
		dpr_sqrt_cell #(.BIT(SQ_BITS - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq_vld[i]),
			.side_i (sq_side[i]),
			.sq_i   (sq_dat[i]),
			.vld_o  (sq_vld[i+1]),
			.side_o (sq_side[i+1]),
			.sq_o   (sq_dat[i+1])
		);
	end

	logic  dv_vld  [0:Q_BITS];
	side_t dv_side [0:Q_BITS];
	dv_t   dv_dat  [0:Q_BITS];

	assign dv_dat[0] = '{
		rem_x: sq_dat[SQ_BITS].num_x,
		rem_y: sq_dat[SQ_BITS].num_y,
		rem_z: sq_dat[SQ_BITS].num_z,
		q_x:   '0,
		q_y:   '0,
		q_z:   '0,
		d:     sq_dat[SQ_BITS].res
	};

	assign dv_vld[0]  = sq_vld[SQ_BITS];
	assign dv_side[0] = sq_side[SQ_BITS];

	for (genvar i = 0; i < Q_BITS; i++) begin : g_div
		dpr_div_cell #(.BIT(Q_BITS - 1 - i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (dv_vld[i]),
			.side_i (dv_side[i]),
			.dv_i   (dv_dat[i]),
			.vld_o  (dv_vld[i+1]),
			.side_o (dv_side[i+1]),
			.dv_o   (dv_dat[i+1])
		);
	end

	// Output selection by mode.
	side_t            fs;
	dv_t              fd;
	logic [OUT_W-1:0] qx, qy;
	coord_t           ox, oy, oz;
	logic             done_q;
	coord_t           recip_x_q, recip_y_q, recip_z_q;

	always_comb begin
		fs = dv_side[Q_BITS];
		fd = dv_dat[Q_BITS];
		qx = OUT_W'(fd.q_x);
		qy = OUT_W'(fd.q_y);
		ox = '0;
		oy = '0;
		oz = '0;
		unique case (mode_q)
			MODE_EWALD: begin
				if (fd.d != '0) begin
					ox = fs.neg_x ? -$signed(qx) : $signed(qx);
					oy = fs.neg_y ? -$signed(qy) : $signed(qy);
					oz = $signed(OUT_W'(radius_q) - OUT_W'(fd.q_z));
				end
			end
			MODE_PLANE: begin
				ox = fs.pln_x;
				oy = fs.pln_y;
			end
			MODE_GRID: begin
				ox = fs.pln_x;
				oy = fs.pln_y;
				oz = fs.pln_z;
			end
			default: begin
				ox = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[Q_BITS];
		end
	end

	always_ff @(posedge clk) begin
		recip_x_q <= ox;
		recip_y_q <= oy;
		recip_z_q <= oz;
	end

	assign done    = done_q;
	assign recip_x = recip_x_q;
	assign recip_y = recip_y_q;
	assign recip_z = recip_z_q;
endmodule

### src/dpr_checker.sv
// ---------------------------------------------------------------------------
// dpr_checker
// Port-level checks on result timing and mode-dependent result values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "detector_pixel_to_reciprocal_coords_top_defines.svh"
module dpr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             done,
	input logic signed [dpr_pkg::OUT_W-1:0] recip_x,
	input logic signed [dpr_pkg::OUT_W-1:0] recip_y,
	input logic signed [dpr_pkg::OUT_W-1:0] recip_z,
	input logic                             cfg_we,
	input logic [dpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [dpr_pkg::CFG_W-1:0]        cfg_data
);
	import dpr_pkg::*;

	logic [1:0] mode_q;
	logic       ewald;
	logic       plane;
	logic       undef;
	logic       all_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GRID;
		end else if (cfg_we && (cfg_index == REG_MODE)) begin
			mode_q <= cfg_data[1:0];
		end
	end

	assign ewald = mode_q == MODE_EWALD;
	assign plane = mode_q == MODE_PLANE;
	assign undef = (mode_q != MODE_EWALD) && (mode_q != MODE_PLANE) && (mode_q != MODE_GRID);
	assign all_zero = (recip_x == '0) && (recip_y == '0) && (recip_z == '0);

	`DPR_ASSERT_IMPLY(a_latency, done, $past(start && !busy, LATENCY), "result without item")
	`DPR_ASSERT_IMPLY(a_plane_z, done && plane, recip_z == '0, "plane result with nonzero z")
	`DPR_ASSERT_IMPLY(a_undef, done && undef, all_zero, "undefined mode result nonzero")
	`DPR_ASSERT_IMPLY(a_ewald_z, done && ewald, !recip_z[OUT_W-1], "sphere z negative")
endmodule

bind detector_pixel_to_reciprocal_coords_top dpr_checker u_dpr_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams detector pixels through the reciprocal coordinate block under
// several register settings (grid, plane, Ewald sphere and the unused mode)
// and compares every result with a scoreboard that recomputes the mapping.
// ---------------------------------------------------------------------------
module tb_top;
	import dpr_pkg::*;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	class coord_scoreboard;
		typedef struct {
			coord_t x;
			coord_t y;
			coord_t z;
		} coords_t;

		coords_t expected_coords[$];
		int errors;
		int results_seen;
		logic [1:0] mode;
		logic [11:0] ctr_x, ctr_y, ctr_z;
		logic [31:0] stp_x, stp_y, stp_z, radius;

		function new();
			reset();
		endfunction

		function void reset();
			mode = MODE_GRID;
			ctr_x = 0; ctr_y = 0; ctr_z = 0;
			stp_x = 0; stp_y = 0; stp_z = 0; radius = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_MODE: mode = val[1:0];
				REG_CENTER_X: ctr_x = val[11:0];
				REG_CENTER_Y: ctr_y = val[11:0];
				REG_CENTER_Z: ctr_z = val[11:0];
				REG_STEP_X: stp_x = val;
				REG_STEP_Y: stp_y = val;
				REG_STEP_Z: stp_z = val;
				REG_RADIUS: radius = val;
				default: ;
			endcase
		endfunction

		// Offset times step, saturated to the 40-bit signed range.
		function logic [39:0] scale(int off, logic [31:0] stp, output bit neg);
			logic [43:0] p;
			p = 44'(off < 0 ? -off : off) * 44'(stp);
			neg = (off < 0) && (p != 0);
			if (neg) begin
				if (p > 44'h80_0000_0000) p = 44'h80_0000_0000;
			end else if (p > 44'h7F_FFFF_FFFF) begin
				p = 44'h7F_FFFF_FFFF;
			end
			return p[39:0];
		endfunction

		function coord_t signed_of(logic [39:0] mag, bit neg);
			return neg ? coord_t'(-mag) : coord_t'(mag);
		endfunction

		function logic [41:0] isqrt(logic [83:0] s);
			logic [41:0] res;
			logic [41:0] c;
			res = 0;
			for (int b = 41; b >= 0; b--) begin
				c = res | (42'd1 << b);
				if (84'(c) * 84'(c) <= s) res = c;
			end
			return res;
		endfunction

		function void note_pixel(logic [11:0] px, logic [11:0] py, logic [11:0] pz);
			coords_t e;
			bit nx, ny, nz;
			logic [39:0] rx, ry, rz;
			logic [83:0] s;
			logic [41:0] d;
			rx = scale(int'(px) - int'(ctr_x), stp_x, nx);
			ry = scale(int'(ctr_y) - int'(py), stp_y, ny);
			rz = scale(int'(ctr_z) - int'(pz), stp_z, nz);
			e.x = 0; e.y = 0; e.z = 0;
			case (mode)
				MODE_EWALD: begin
					s = 84'(rx) * 84'(rx) + 84'(ry) * 84'(ry) + 84'(radius) * 84'(radius);
					d = isqrt(s);
					if (d != 0) begin
						e.x = signed_of(40'((84'(rx) * 84'(radius)) / 84'(d)), nx);
						e.y = signed_of(40'((84'(ry) * 84'(radius)) / 84'(d)), ny);
						e.z = coord_t'(40'(radius) -
							40'((84'(radius) * 84'(radius)) / 84'(d)));
					end
				end
				MODE_PLANE: begin
					e.x = signed_of(rx, nx);
					e.y = signed_of(ry, ny);
				end
				MODE_GRID: begin
					e.x = signed_of(rx, nx);
					e.y = signed_of(ry, ny);
					e.z = signed_of(rz, nz);
				end
				default: ;
			endcase
			expected_coords.push_back(e);
		endfunction

		function void check_coords(coord_t ax, coord_t ay, coord_t az);
			coords_t e;
			results_seen++;
			if (expected_coords.size() == 0) begin
				$display("%0t: result with no item pending: x=%0d y=%0d z=%0d",
					$time, ax, ay, az);
				errors++;
				return;
			end
			e = expected_coords.pop_front();
			if (ax !== e.x) begin
				$display("%0t: recip_x expected %0d actual %0d", $time, e.x, ax);
				errors++;
			end
			if (ay !== e.y) begin
				$display("%0t: recip_y expected %0d actual %0d", $time, e.y, ay);
				errors++;
			end
			if (az !== e.z) begin
				$display("%0t: recip_z expected %0d actual %0d", $time, e.z, az);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [11:0] pix_x = 0, pix_y = 0, pix_z = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
	logic [CFG_W-1:0] cfg_data = 0;
	logic busy, done;
	coord_t recip_x, recip_y, recip_z;

	coord_scoreboard sb = new();
	int cycles = 0;
	int items_sent = 0;
	int idle_pct = 0;

	detector_pixel_to_reciprocal_coords_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pix_x(pix_x), .pix_y(pix_y), .pix_z(pix_z),
		.done(done), .recip_x(recip_x), .recip_y(recip_y), .recip_z(recip_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy) sb.note_pixel(pix_x, pix_y, pix_z);
			if (done) sb.check_coords(recip_x, recip_y, recip_z);
		end
	end

	task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [11:0] z);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(negedge clk);
		end
		start <= 1;
		pix_x <= x;
		pix_y <= y;
		pix_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 0;
		while (sb.expected_coords.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_regs(logic [1:0] m, logic [11:0] cx, logic [11:0] cy,
		logic [11:0] cz, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [31:0] r);
		logic [CFG_W-1:0] vals[8];
		vals = '{32'(m), 32'(cx), 32'(cy), 32'(cz), sx, sy, sz, r};
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we <= 1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(CFG_IDX_W'(i), vals[i]);
		end
		@(negedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [11:0] pick_coord();
		case ($urandom_range(9))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2, 3: return 32'($urandom_range(0, 32'h0040_0000));
			4: return 32'($urandom_range(0, 32'h1000_0000));
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(int n, logic [1:0] m, logic [11:0] cx, logic [11:0] cy,
		logic [11:0] cz, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [31:0] r);
		wait_idle();
		load_regs(m, cx, cy, cz, sx, sy, sz, r);
		send_pixel(12'd0, 12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF, 12'hFFF);
		send_pixel(cx, cy, cz);
		for (int i = 0; i < n; i++) send_pixel(pick_coord(), pick_coord(), pick_coord());
	endtask

	task automatic random_phase(int n);
		run_phase(n, 2'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord(),
			pick_step(), pick_step(), pick_step(), pick_step());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Reset values give a grid with zero steps.
		send_pixel(12'hFFF, 12'h0, 12'h800);
		run_phase(1, MODE_GRID, 12'd2048, 12'd2048, 12'd2048,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		run_phase(1, MODE_PLANE, 12'd100, 12'd4000, 12'd7,
			32'h0010_0000, 32'h0000_8000, 32'hFFFF_FFFF, 32'd0);
		run_phase(1, MODE_EWALD, 12'd1024, 12'd1024, 12'd0,
			32'd0, 32'd0, 32'd0, 32'd0);
		run_phase(2, MODE_EWALD, 12'd2048, 12'd2048, 12'd0,
			32'h0000_1000, 32'h0000_2000, 32'd5, 32'h0100_0000);
		run_phase(1, MODE_EWALD, 12'd0, 12'd4095, 12'd0,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		run_phase(1, MODE_NONE, 12'd5, 12'd5, 12'd5,
			32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);

		idle_pct = 19;
		repeat (4) random_phase(40);
		idle_pct = 56;
		repeat (4) random_phase(40);
		idle_pct = 0;
		repeat (4) random_phase(40);

		wait_idle();
		$display("Sent %0d pixels, checked %0d results across grid, plane, sphere",
			items_sent, sb.results_seen);
		$display("and unused mode settings, with step and radius extremes.");
		if (sb.errors == 0 && sb.expected_coords.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule

### detector_pixel_to_reciprocal_coords_top.f
+incdir+src
src/dpr_pkg.sv
src/dpr_sqrt_cell.sv
src/dpr_div_cell.sv
src/detector_pixel_to_reciprocal_coords_top.sv
src/dpr_checker.sv
tb/tb_top.sv
